### sv/flog_pkg.sv
package flog_pkg;

  localparam int unsigned JOURNAL_SLOTS_DEF      = 1365;
  localparam int unsigned FLASH_LAST_ADDRESS_DEF = 2097151;
  localparam int unsigned DATA_BASE_DEF          = 4096;

  typedef enum logic [2:0] {
    MODE_HEADER  = 3'd0,
    MODE_DATA    = 3'd1,
    MODE_ERASE   = 3'd2,
    MODE_READOUT = 3'd3,
    MODE_RESTORE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE         = 2'd0,
    CMD_PROGRAM      = 2'd1,
    CMD_ERASE_SECTOR = 2'd2,
    CMD_CHIP_ERASE   = 2'd3
  } cmd_e;

  // position of the result walker inside one item's command list
  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_ERASE = 3'd1,
    PH_J0    = 3'd2,
    PH_J1    = 3'd3,
    PH_J2    = 3'd4
  } phase_e;

  localparam logic CFG_WRITE_DISABLE = 1'b0;
  localparam logic CFG_MEMORY_LOCKED = 1'b1;

  typedef struct packed {
    logic [10:0] restore_slot;
    logic [21:0] restore_address;
    logic [7:0]  value;
    logic [2:0]  mode;
  } item_t;

  typedef struct packed {
    cmd_e        first_cmd;
    logic [20:0] first_addr;
    logic [7:0]  first_data;
    logic        has_journal;
    logic        has_erase;
    logic [11:0] jbase;
    logic [21:0] wp;
    logic        refused;
    logic        no_space;
    logic        journal_full;
    logic        pointer_known;
  } plan_t;

endpackage

### sv/flog_in_stage.sv
module flog_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [47:0]     s_axis_tdata,   // value[7:0], restore_address[29:8], restore_slot[40:30]
  input  logic [2:0]      s_axis_tuser,   // mode[2:0]
  input  logic            load_i,
  output logic            valid_o,
  output flog_pkg::item_t item_o
);
  import flog_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign s_axis_tready = !valid_q || load_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (load_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode            <= s_axis_tuser;
      item_q.value           <= s_axis_tdata[7:0];
      item_q.restore_address <= s_axis_tdata[29:8];
      item_q.restore_slot    <= s_axis_tdata[40:30];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### sv/flog_core.sv
module flog_core #(
  parameter int unsigned JournalSlots     = flog_pkg::JOURNAL_SLOTS_DEF,
  parameter int unsigned FlashLastAddress = flog_pkg::FLASH_LAST_ADDRESS_DEF,
  parameter int unsigned DataBase         = flog_pkg::DATA_BASE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic            cfg_data_i,
  input  flog_pkg::item_t item_i,
  input  logic            load_i,
  output flog_pkg::plan_t plan_o
);
  import flog_pkg::*;

  localparam logic [24:0] LastW   = 25'(FlashLastAddress);
  localparam logic [24:0] LastP1W = 25'(FlashLastAddress + 1);
  localparam logic [24:0] BaseW   = 25'(DataBase);
  localparam logic [10:0] SlotsW  = 11'(JournalSlots);

  logic [21:0] wp_q, wp_d;
  logic [10:0] slot_q, slot_d;
  logic        jfull_q, jfull_d;
  logic        pvalid_q, pvalid_d;
  logic        rdone_q, rdone_d;
  logic        refused_q, refused_d;
  logic        nospace_q, nospace_d;
  logic [7:0]  remain_q, remain_d;
  logic        wdis_q, lock_q;

  logic        blocked;
  logic [24:0] frame_end;
  logic [24:0] raddr_w;
  logic [7:0]  remain_dec;
  logic        erase_need;
  logic [10:0] slot_use;
  logic [10:0] slot_inc;
  plan_t       plan;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    blocked    = wdis_q || lock_q;
    frame_end  = {3'b0, wp_q} + {17'b0, item_i.value} - 25'd1;
    raddr_w    = {3'b0, item_i.restore_address};
    remain_dec = remain_q - 8'd1;
    erase_need = jfull_q || (slot_q >= SlotsW);
    slot_use   = erase_need ? 11'd0 : slot_q;
    slot_inc   = slot_use + 11'd1;

    wp_d      = wp_q;
    slot_d    = slot_q;
    jfull_d   = jfull_q;
    pvalid_d  = pvalid_q;
    rdone_d   = rdone_q;
    refused_d = refused_q;
    nospace_d = nospace_q;
    remain_d  = remain_q;

    plan             = '0;
    plan.first_cmd   = CMD_NONE;
    plan.jbase       = {1'b0, slot_use} + {slot_use, 1'b0};

    case (mode_e'(item_i.mode))
      MODE_HEADER: begin
        remain_d = 8'd0;
        if (blocked || !pvalid_q) begin
          refused_d = 1'b1;
        end else begin
          refused_d = 1'b0;
          if (item_i.value != 8'd0) begin
            if (frame_end > LastW) begin
              nospace_d = 1'b1;
            end else begin
              nospace_d = 1'b0;
              remain_d  = item_i.value;
            end
          end
        end
      end
      MODE_DATA: begin
        if (blocked) begin
          refused_d = 1'b1;
          remain_d  = 8'd0;
        end else if (remain_q != 8'd0) begin
          plan.first_cmd  = CMD_PROGRAM;
          plan.first_addr = wp_q[20:0];
          plan.first_data = item_i.value;
          wp_d            = wp_q + 22'd1;
          remain_d        = remain_dec;
          // frame closes: journal the new pointer, erase sector first when full
          if (remain_dec == 8'd0) begin
            plan.has_journal = 1'b1;
            plan.has_erase   = erase_need;
            slot_d           = slot_inc;
            jfull_d          = slot_inc >= SlotsW;
          end
        end
      end
      MODE_ERASE: begin
        if (blocked || !rdone_q) begin
          refused_d = 1'b1;
          if (blocked) begin
            remain_d = 8'd0;
          end
        end else begin
          plan.first_cmd = CMD_CHIP_ERASE;
          refused_d      = 1'b0;
          nospace_d      = 1'b0;
          jfull_d        = 1'b0;
          rdone_d        = 1'b0;
          wp_d           = BaseW[21:0];
          slot_d         = 11'd0;
          pvalid_d       = 1'b1;
          remain_d       = 8'd0;
        end
      end
      MODE_READOUT: begin
        rdone_d = 1'b1;
      end
      MODE_RESTORE: begin
        remain_d = 8'd0;
        if (raddr_w < BaseW || raddr_w > LastP1W) begin
          pvalid_d = 1'b0;
        end else begin
          wp_d     = item_i.restore_address;
          pvalid_d = 1'b1;
          if (item_i.restore_slot >= SlotsW) begin
            slot_d  = SlotsW;
            jfull_d = 1'b1;
          end else begin
            slot_d  = item_i.restore_slot;
            jfull_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    plan.wp            = wp_d;
    plan.refused       = refused_d;
    plan.no_space      = nospace_d;
    plan.journal_full  = jfull_d;
    plan.pointer_known = pvalid_d;
  end

  assign plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= BaseW[21:0];
      slot_q    <= 11'd0;
      jfull_q   <= 1'b0;
      pvalid_q  <= 1'b0;
      rdone_q   <= 1'b0;
      refused_q <= 1'b0;
      nospace_q <= 1'b0;
      remain_q  <= 8'd0;
    end else if (load_i) begin
      wp_q      <= wp_d;
      slot_q    <= slot_d;
      jfull_q   <= jfull_d;
      pvalid_q  <= pvalid_d;
      rdone_q   <= rdone_d;
      refused_q <= refused_d;
      nospace_q <= nospace_d;
      remain_q  <= remain_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdis_q <= 1'b0;
      lock_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WRITE_DISABLE: wdis_q <= cfg_data_i;
        CFG_MEMORY_LOCKED: lock_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/flog_emit.sv
module flog_emit #(
  parameter int unsigned FlashLastAddress = flog_pkg::FLASH_LAST_ADDRESS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flog_pkg::plan_t plan_i,
  input  logic            load_i,
  output logic            take_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [55:0]     m_axis_tdata,  // flash_address[20:0], flash_data[28:21], refused[29],
                                         // no_space[30], journal_full[31],
                                         // pointer_known[32], free_bytes[54:33]
  output logic [1:0]      m_axis_tuser,  // command[1:0]
  output logic            m_axis_tlast
);
  import flog_pkg::*;

  localparam logic [24:0] LastP1W = 25'(FlashLastAddress + 1);

  plan_t       plan_q;
  logic        plan_valid_q, plan_valid_d;
  phase_e      phase_q, phase_d;
  logic        fire;
  logic        out_last;
  cmd_e        cmd;
  logic [20:0] addr;
  logic [7:0]  data;
  logic [24:0] wp_w;
  logic [21:0] free_bytes;

  assign out_last = (phase_q == PH_FIRST && !plan_q.has_journal) || phase_q == PH_J2;
  assign fire     = plan_valid_q && m_axis_tready;
  assign take_o   = !plan_valid_q || (fire && out_last);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      case (phase_q)
        PH_FIRST: begin
          if (plan_q.has_journal) begin
            phase_d = plan_q.has_erase ? PH_ERASE : PH_J0;
          end
        end
        PH_ERASE: phase_d = PH_J0;
        PH_J0:    phase_d = PH_J1;
        PH_J1:    phase_d = PH_J2;
        PH_J2:    phase_d = PH_FIRST;
        default:  phase_d = PH_FIRST;
      endcase
    end
  end

  always_comb begin
    plan_valid_d = plan_valid_q;
    if (load_i) begin
      plan_valid_d = 1'b1;
    end else if (fire && out_last) begin
      plan_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_valid_q <= 1'b0;
      phase_q      <= PH_FIRST;
    end else begin
      plan_valid_q <= plan_valid_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q <= plan_i;
    end
  end

  // result fields for the current phase
  always_comb begin
    case (phase_q)
      PH_FIRST: begin
        cmd  = plan_q.first_cmd;
        addr = plan_q.first_addr;
        data = plan_q.first_data;
      end
      PH_ERASE: begin
        cmd  = CMD_ERASE_SECTOR;
        addr = 21'd0;
        data = 8'd0;
      end
      PH_J0: begin
        cmd  = CMD_PROGRAM;
        addr = {9'b0, plan_q.jbase};
        data = {2'b0, plan_q.wp[21:16]};
      end
      PH_J1: begin
        cmd  = CMD_PROGRAM;
        addr = {9'b0, plan_q.jbase} + 21'd1;
        data = plan_q.wp[15:8];
      end
      PH_J2: begin
        cmd  = CMD_PROGRAM;
        addr = {9'b0, plan_q.jbase} + 21'd2;
        data = plan_q.wp[7:0];
      end
      default: begin
        cmd  = CMD_NONE;
        addr = 21'd0;
        data = 8'd0;
      end
    endcase
  end

  always_comb begin
    wp_w       = {3'b0, plan_q.wp};
    free_bytes = (LastP1W > wp_w) ? 22'(LastP1W - wp_w) : 22'd0;
  end

  assign m_axis_tvalid = plan_valid_q;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = cmd;
  assign m_axis_tdata  = {1'b0, free_bytes, plan_q.pointer_known, plan_q.journal_full,
                          plan_q.no_space, plan_q.refused, data, addr};

  a_phase_needs_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_FIRST |-> plan_valid_q)
    else $error("walker past first result without a plan");

  a_erase_only_when_planned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERASE |-> plan_q.has_erase && plan_q.has_journal)
    else $error("sector erase issued without journal erase request");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_valid_q && !m_axis_tready |=> plan_valid_q && $stable(phase_q))
    else $error("result walker moved while stalled");

  a_journal_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_J2 |=> phase_q == PH_FIRST)
    else $error("walker did not return after last journal byte");

endmodule

### sv/flash_log_append_with_pointer_journal.sv
// An accepted item is registered in the input stage and decoded by the core; its plan
// is registered in the emitter once the results of the previous item are all taken.
// Results: an item yields 1 to 5 results; the result walker sends one per cycle while
// m_axis_tready is high: one for a status, mid-frame byte or chip erase, four for a
// frame-closing byte and five for a frame-closing byte with sector erase.
// Reset: pointer at the data base and not valid, slot and all flags cleared.
module flash_log_append_with_pointer_journal #(
  parameter int unsigned JournalSlots     = flog_pkg::JOURNAL_SLOTS_DEF,
  parameter int unsigned FlashLastAddress = flog_pkg::FLASH_LAST_ADDRESS_DEF,
  parameter int unsigned DataBase         = flog_pkg::DATA_BASE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // value[7:0], restore_address[29:8], restore_slot[40:30]
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // flash_address[20:0], flash_data[28:21], refused[29],
                                     // no_space[30], journal_full[31],
                                     // pointer_known[32], free_bytes[54:33]
  output logic [1:0]  m_axis_tuser,  // command[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i
);
  import flog_pkg::*;

  item_t item;
  plan_t plan;
  logic  item_valid;
  logic  take;
  logic  load;

  assign load = item_valid && take;

  flog_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .load_i        (load),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  flog_core #(
    .JournalSlots     (JournalSlots),
    .FlashLastAddress (FlashLastAddress),
    .DataBase         (DataBase)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .load_i      (load),
    .plan_o      (plan)
  );

  flog_emit #(
    .FlashLastAddress (FlashLastAddress)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .plan_i        (plan),
    .load_i        (load),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### dv/flash_log_append_with_pointer_journal_tb.sv
`timescale 1ns / 1ps

module flash_log_append_with_pointer_journal_tb;
  import flog_pkg::*;

  localparam int unsigned SLOTS       = JOURNAL_SLOTS_DEF;
  localparam int unsigned LAST_ADDR   = FLASH_LAST_ADDRESS_DEF;
  localparam int unsigned BASE_ADDR   = DATA_BASE_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned MAX_GAP     = 8;
  localparam int          FIRST_SPARE_MODE = 5;
  localparam int          LAST_SPARE_MODE  = 7;

  typedef struct {
    cmd_e        cmd;
    logic [20:0] addr;
    logic [7:0]  data;
    logic        last;
    logic        refused;
    logic        no_space;
    logic        journal_full;
    logic        pointer_known;
    logic [21:0] free_bytes;
  } flash_cmd_t;

  class log_scoreboard;
    logic [21:0] wp;
    logic [10:0] slot;
    logic        jfull;
    logic        pvalid;
    logic        readout;
    logic        refused;
    logic        nospace;
    logic [7:0]  remaining;
    logic        wr_disable;
    logic        locked;
    flash_cmd_t  expected_cmds[$];
    flash_cmd_t  batch[$];
    int          items;
    int          results;
    int          mismatches;
    int          programs;
    int          sector_erases;
    int          chip_erases;

    function new();
      wp         = 22'(BASE_ADDR);
      slot       = '0;
      jfull      = 1'b0;
      pvalid     = 1'b0;
      readout    = 1'b0;
      refused    = 1'b0;
      nospace    = 1'b0;
      remaining  = '0;
      wr_disable = 1'b0;
      locked     = 1'b0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == CFG_WRITE_DISABLE) wr_disable = val;
      else locked = val;
    endfunction

    function void add_cmd(cmd_e c, logic [20:0] a, logic [7:0] d);
      flash_cmd_t r;
      r.cmd           = c;
      r.addr          = a;
      r.data          = d;
      r.last          = 1'b0;
      r.refused       = 1'b0;
      r.no_space      = 1'b0;
      r.journal_full  = 1'b0;
      r.pointer_known = 1'b0;
      r.free_bytes    = '0;
      batch.push_back(r);
    endfunction

    // Work out the flash commands one input item causes and queue them.
    function void note_item(item_t it);
      logic        blocked;
      logic [11:0] jbase;
      logic [21:0] fb;
      blocked = wr_disable | locked;
      batch.delete();
      items++;
      case (it.mode)
        MODE_HEADER: begin
          remaining = '0;
          if (blocked || !pvalid) begin
            refused = 1'b1;
          end else begin
            refused = 1'b0;
            if (it.value != 0) begin
              if (32'(wp) + 32'(it.value) - 32'd1 > LAST_ADDR) begin
                nospace = 1'b1;
              end else begin
                nospace   = 1'b0;
                remaining = it.value;
              end
            end
          end
        end
        MODE_DATA: begin
          if (blocked) begin
            refused   = 1'b1;
            remaining = '0;
          end else if (remaining != 0) begin
            add_cmd(CMD_PROGRAM, wp[20:0], it.value);
            wp        = wp + 22'd1;
            remaining = remaining - 8'd1;
            if (remaining == 0) begin
              // journal the new pointer, erasing sector 0 first when full
              if (jfull || slot >= 11'(SLOTS)) begin
                add_cmd(CMD_ERASE_SECTOR, '0, '0);
                jfull = 1'b0;
                slot  = '0;
              end
              jbase = slot * 12'd3;
              add_cmd(CMD_PROGRAM, 21'(jbase), 8'(wp >> 16));
              add_cmd(CMD_PROGRAM, 21'(jbase + 12'd1), wp[15:8]);
              add_cmd(CMD_PROGRAM, 21'(jbase + 12'd2), wp[7:0]);
              slot = slot + 11'd1;
              if (slot >= 11'(SLOTS)) jfull = 1'b1;
            end
          end
        end
        MODE_ERASE: begin
          if (blocked || !readout) begin
            refused = 1'b1;
            if (blocked) remaining = '0;
          end else begin
            add_cmd(CMD_CHIP_ERASE, '0, '0);
            refused   = 1'b0;
            nospace   = 1'b0;
            jfull     = 1'b0;
            readout   = 1'b0;
            wp        = 22'(BASE_ADDR);
            slot      = '0;
            pvalid    = 1'b1;
            remaining = '0;
          end
        end
        MODE_READOUT: readout = 1'b1;
        MODE_RESTORE: begin
          remaining = '0;
          if (32'(it.restore_address) < BASE_ADDR ||
              32'(it.restore_address) > LAST_ADDR + 1) begin
            pvalid = 1'b0;
          end else begin
            wp     = it.restore_address;
            pvalid = 1'b1;
            if (it.restore_slot >= 11'(SLOTS)) begin
              slot  = 11'(SLOTS);
              jfull = 1'b1;
            end else begin
              slot  = it.restore_slot;
              jfull = 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (batch.size() == 0) add_cmd(CMD_NONE, '0, '0);
      fb = (LAST_ADDR + 1 > 32'(wp)) ? 22'(LAST_ADDR + 1 - 32'(wp)) : '0;
      foreach (batch[i]) begin
        batch[i].last          = (i == batch.size() - 1);
        batch[i].refused       = refused;
        batch[i].no_space      = nospace;
        batch[i].journal_full  = jfull;
        batch[i].pointer_known = pvalid;
        batch[i].free_bytes    = fb;
        expected_cmds.push_back(batch[i]);
      end
    endfunction

    function string fmt(flash_cmd_t c);
      return $sformatf("cmd %0d addr %h data %h last %b ref %b nosp %b full %b known %b free %0d",
                       c.cmd, c.addr, c.data, c.last, c.refused, c.no_space,
                       c.journal_full, c.pointer_known, c.free_bytes);
    endfunction

    function void check_result(flash_cmd_t got);
      flash_cmd_t want;
      results++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: flash command with no item pending: %s", $time, fmt(got));
        return;
      end
      want = expected_cmds.pop_front();
      case (want.cmd)
        CMD_PROGRAM:      programs++;
        CMD_ERASE_SECTOR: sector_erases++;
        CMD_CHIP_ERASE:   chip_erases++;
        default: ;
      endcase
      if (want.cmd !== got.cmd || want.addr !== got.addr || want.data !== got.data ||
          want.last !== got.last || want.refused !== got.refused ||
          want.no_space !== got.no_space || want.journal_full !== got.journal_full ||
          want.pointer_known !== got.pointer_known || want.free_bytes !== got.free_bytes) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: flash command mismatch", $time);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic        cfg_data_i;

  log_scoreboard sb;
  bit            idle_on;
  bit            hold_req;
  int unsigned   quiet;

  always #10 clk_i = ~clk_i;

  flash_log_append_with_pointer_journal i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  task automatic send(input logic [2:0] mode, input logic [7:0] val,
                      input logic [21:0] raddr, input logic [10:0] rslot);
    item_t       it;
    int unsigned gap;
    it.mode            = mode;
    it.value           = val;
    it.restore_address = raddr;
    it.restore_slot    = rslot;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, rslot, raddr, val};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // let the result walker settle before touching a register
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Mostly well-formed frames with random content, some erase cycles, some noise.
  task automatic rand_traffic(input int count);
    int          sent;
    int          pick;
    int          len;
    logic [21:0] addr;
    logic [10:0] slot;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 9) == 0) addr = 22'($urandom_range(LAST_ADDR - 8, LAST_ADDR + 1));
          else addr = 22'(BASE_ADDR + $urandom_range(0, 65535));
          pick = $urandom_range(0, 19);
          if (pick < 3) slot = 11'($urandom_range(SLOTS, 2047));
          else if (pick < 6) slot = 11'($urandom_range(SLOTS - 3, SLOTS - 1));
          else slot = 11'($urandom_range(0, SLOTS - 1));
          send(MODE_RESTORE, 8'($urandom), addr, slot);
          sent++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 90) len = $urandom_range(1, 6);
        else if (pick < 97) len = $urandom_range(7, 40);
        else len = $urandom_range(0, 255);
        send(MODE_HEADER, 8'(len), 22'($urandom), 11'($urandom));
        sent++;
        for (int k = 0; k < len; k++) begin
          // cut a frame short now and then
          if ($urandom_range(0, 29) == 0) break;
          send(MODE_DATA, 8'($urandom), 22'($urandom), 11'($urandom));
          sent++;
        end
      end else if (pick < 66) begin
        send(MODE_READOUT, 8'($urandom), 22'($urandom), 11'($urandom));
        sent++;
        if ($urandom_range(0, 1) == 0) begin
          send(MODE_ERASE, 8'($urandom), 22'($urandom), 11'($urandom));
          sent++;
        end
      end else begin
        send(3'($urandom_range(0, 7)), 8'($urandom), 22'($urandom), 11'($urandom));
        sent++;
      end
    end
  endtask

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    int unsigned gap;
    bit          hold_done;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    flash_cmd_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cmd           = cmd_e'(m_axis_tuser);
      got.addr          = m_axis_tdata[20:0];
      got.data          = m_axis_tdata[28:21];
      got.last          = m_axis_tlast;
      got.refused       = m_axis_tdata[29];
      got.no_space      = m_axis_tdata[30];
      got.journal_full  = m_axis_tdata[31];
      got.pointer_known = m_axis_tdata[32];
      got.free_bytes    = m_axis_tdata[54:33];
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", quiet);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = 1'b0;
    idle_on       = 1'b1;
    sb            = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_WRITE_DISABLE, 1'b0);
    write_reg(CFG_MEMORY_LOCKED, 1'b0);

    // pointer unknown, erase before read-out, then a clean erase
    send(MODE_HEADER, 8'd5, '0, '0);
    send(MODE_DATA, 8'hFF, '0, '0);
    send(MODE_ERASE, '0, '0, '0);
    send(MODE_READOUT, '0, '0, '0);
    send(MODE_ERASE, '0, '0, '0);
    // zero length, a short frame, then a frame abandoned by a new header
    send(MODE_HEADER, 8'd0, '0, '0);
    send(MODE_HEADER, 8'd2, '0, '0);
    send(MODE_DATA, 8'h00, '0, '0);
    send(MODE_DATA, 8'hFF, '0, '0);
    send(MODE_HEADER, 8'd3, '0, '0);
    send(MODE_DATA, 8'hA5, '0, '0);
    send(MODE_HEADER, 8'd1, '0, '0);
    send(MODE_DATA, 8'h5A, '0, '0);
    for (int m = FIRST_SPARE_MODE; m <= LAST_SPARE_MODE; m++)
      send(3'(m), 8'hFF, 22'h3FFFFF, 11'h7FF);
    // restore: just below the data base and just past the end are invalid
    send(MODE_RESTORE, '0, 22'(BASE_ADDR - 1), 11'd7);
    send(MODE_RESTORE, '0, 22'(LAST_ADDR + 2), 11'd7);
    // last byte of flash, last journal slot
    send(MODE_RESTORE, '0, 22'(LAST_ADDR), 11'(SLOTS - 1));
    send(MODE_HEADER, 8'd255, '0, '0);
    send(MODE_HEADER, 8'd1, '0, '0);
    send(MODE_DATA, 8'h3C, '0, '0);
    send(MODE_HEADER, 8'd1, '0, '0);
    // saturated slot forces a sector erase before the next journal entry
    send(MODE_RESTORE, '0, 22'(BASE_ADDR), 11'h7FF);
    send(MODE_HEADER, 8'd1, '0, '0);
    send(MODE_DATA, 8'h81, '0, '0);

    rand_traffic(100);
    hold_req = 1'b1;
    rand_traffic(25);

    write_reg(CFG_WRITE_DISABLE, 1'b1);
    rand_traffic(25);
    write_reg(CFG_WRITE_DISABLE, 1'b0);
    write_reg(CFG_MEMORY_LOCKED, 1'b1);
    rand_traffic(20);
    write_reg(CFG_WRITE_DISABLE, 1'b1);
    rand_traffic(10);
    write_reg(CFG_WRITE_DISABLE, 1'b0);
    write_reg(CFG_MEMORY_LOCKED, 1'b0);
    idle_on = 1'b0;
    rand_traffic(40);
    idle_on = 1'b1;
    rand_traffic(20);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d items through all lock and write-disable settings, %0d results checked",
             sb.items, sb.results);
    $display("  byte programs %0d, sector erases %0d, chip erases %0d, mismatches %0d",
             sb.programs, sb.sector_erases, sb.chip_erases, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
